// File: hw/rtl/mme_pkg.sv
package mme_pkg;

	localparam int ROW_BITS = 3;
	localparam int COL_BITS = 3;
	localparam int IN_VALUE_BITS = 16;
	localparam int DOT_BITS = 36;
	localparam int DIM_REG_BITS = 4;
	localparam int REG_INDEX_BITS = 2;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	localparam logic [REG_INDEX_BITS-1:0] REG_ROWS_A = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_COLS_B = 2'd2;

	localparam logic [DIM_REG_BITS-1:0] DIM_RESET = 4'd8;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [ROW_BITS-1:0] elem_row;
		logic [COL_BITS-1:0] elem_col;
		logic signed [IN_VALUE_BITS-1:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
		logic signed [DOT_BITS-1:0] dot_value;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [REG_INDEX_BITS-1:0] reg_index;
		logic [DIM_REG_BITS-1:0] wdata;
	} cfg_item_t;

endpackage

// File: hw/rtl/mme_stream_if.sv
interface mme_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/matrix_multiply_engine_top.sv
// Dense matrix multiply C = A x B. A load item (op A or B) writes one element into the A or
// B store; the block then takes the next item in the following cycle. A run item
// streams all rows_a x cols_b elements of C in row-major order, the final one marked by last.
// Each element sums inner_len products: every cycle, unless the pipeline stalls, the sequencer
// reads one entry of A and one of B through the single read port of each store, multiplies and
// accumulates. The whole multiply pipeline stalls when a finished sum meets a full output
// register whose result is not taken. No new item is taken until a run has drained
// into the output register; that register may still hold the last result while loads go on.
// Stores come out of reset uninitialized and must be written before a run reads them.
module matrix_multiply_engine_top
	import mme_pkg::*;
#(
	parameter int MAX_DIM = 8,
	parameter int ELEM_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	mme_stream_if.sink item,
	mme_stream_if.source result,
	mme_stream_if.sink cfg
);

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int PROD_W = 2 * ELEM_BITS;

	function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_REG_BITS-1:0] v);
		if (v == '0)
			return '0;
		if (int'(v) > MAX_DIM)
			return IDX_W'(MAX_DIM - 1);
		return IDX_W'(v - DIM_REG_BITS'(1));
	endfunction

	// configuration
	logic [DIM_REG_BITS-1:0] rows_a_q, inner_len_q, cols_b_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DIM_RESET;
			inner_len_q <= DIM_RESET;
			cols_b_q <= DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				REG_ROWS_A: rows_a_q <= cfg.data.wdata;
				REG_INNER_LEN: inner_len_q <= cfg.data.wdata;
				REG_COLS_B: cols_b_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// control
	state_t state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [IDX_W-1:0] nr_m1_q, nk_m1_q, nc_m1_q;
	logic v_s1, v_s2;
	logic first_s1, fin_s1, lastel_s1;
	logic first_s2, fin_s2, lastel_s2;
	logic [IDX_W-1:0] row_s1, col_s1, row_s2, col_s2;
	logic out_valid_q;
	out_item_t out_q;

	logic in_xfer, run_xfer, wr_a, wr_b, in_range;
	logic stall, issue, k_end, j_end, i_end;

	assign stall = v_s2 && fin_s2 && out_valid_q && !result.ready;
	assign k_end = (k_q == nk_m1_q);
	assign j_end = (j_q == nc_m1_q);
	assign i_end = (i_q == nr_m1_q);

	always_comb begin
		state_d = state_q;
		item.ready = 1'b0;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item.ready = !v_s1 && !v_s2;
				if (run_xfer)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = !stall;
				if (issue && k_end && j_end && i_end)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_xfer = item.valid && item.ready;
	assign run_xfer = in_xfer && (item.data.op == OP_RUN);
	assign in_range = (int'(item.data.elem_row) < MAX_DIM) && (int'(item.data.elem_col) < MAX_DIM);
	assign wr_a = in_xfer && (item.data.op == OP_LOAD_A) && in_range;
	assign wr_b = in_xfer && (item.data.op == OP_LOAD_B) && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// loop counters over i, j, k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			nr_m1_q <= '0;
			nk_m1_q <= '0;
			nc_m1_q <= '0;
		end else if (run_xfer) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			nr_m1_q <= dim_m1(rows_a_q);
			nk_m1_q <= dim_m1(inner_len_q);
			nc_m1_q <= dim_m1(cols_b_q);
		end else if (issue) begin
			if (k_end) begin
				k_q <= '0;
				if (j_end) begin
					j_q <= '0;
					if (!i_end)
						i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	// element stores
	logic signed [ELEM_BITS-1:0] mem_a [DEPTH];
	logic signed [ELEM_BITS-1:0] mem_b [DEPTH];
	logic signed [ELEM_BITS-1:0] a_rd_s1, b_rd_s1;
	logic signed [ELEM_BITS-1:0] wr_elem;
	logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

	assign wr_elem = ELEM_BITS'(item.data.elem_value);
	assign wr_addr = AW'(int'(item.data.elem_row) * MAX_DIM + int'(item.data.elem_col));
	assign rd_addr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
	assign rd_addr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));

	always_ff @(posedge clk) begin
		if (wr_a)
			mem_a[wr_addr] <= wr_elem;
		if (issue)
			a_rd_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			mem_b[wr_addr] <= wr_elem;
		if (issue)
			b_rd_s1 <= mem_b[rd_addr_b];
	end

	// multiply-accumulate pipeline
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [63:0] prod_wide;
	logic signed [DOT_BITS-1:0] prod_dot, acc_q, acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			first_s1 <= (k_q == '0);
			fin_s1 <= k_end;
			lastel_s1 <= i_end && j_end;
			row_s1 <= i_q;
			col_s1 <= j_q;
			prod_s2 <= a_rd_s1 * b_rd_s1;
			first_s2 <= first_s1;
			fin_s2 <= fin_s1;
			lastel_s2 <= lastel_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
		end
	end

	// products are sign-extended to the result width; the sums wrap in two's complement
	assign prod_wide = 64'(prod_s2);
	assign prod_dot = prod_wide[DOT_BITS-1:0];
	assign acc_sum = (first_s2 ? '0 : acc_q) + prod_dot;

	always_ff @(posedge clk) begin
		if (v_s2 && !stall)
			acc_q <= acc_sum;
		if (v_s2 && fin_s2 && !stall) begin
			out_q.out_row <= ROW_BITS'(row_s2);
			out_q.out_col <= COL_BITS'(col_s2);
			out_q.dot_value <= acc_sum;
			out_q.last <= lastel_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (v_s2 && fin_s2 && !stall)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

	// checks
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		run_xfer |=> (state_q == ST_RUN))
		else $error("run transfer did not start the sequencer");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= nk_m1_q))
		else $error("inner counter beyond inner length");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.data)))
		else $error("waiting result dropped or changed");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_a || wr_b) |-> (!v_s1 && !v_s2 && (state_q == ST_IDLE)))
		else $error("store written while a run is in flight");

endmodule

// File: sim/tb_matrix_multiply_engine_top.sv
`timescale 1ns / 100ps

module tb_matrix_multiply_engine_top;
	import mme_pkg::*;

	localparam int MAX_DIM = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int CALM_FROM = 600;
	localparam int CALM_TO = 1400;
	localparam int ITEM_TARGET = 220;

	typedef enum logic [1:0] {
		SEND_ITEM,
		SEND_CFG,
		WAIT_IDLE
	} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		in_item_t item;
		cfg_item_t cfg;
	} plan_step_t;

	logic clk;
	logic arst_n;

	mme_stream_if #(.payload_t(in_item_t)) item_if ();
	mme_stream_if #(.payload_t(out_item_t)) result_if ();
	mme_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

	matrix_multiply_engine_top #(
		.MAX_DIM(MAX_DIM),
		.ELEM_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	plan_step_t pending_steps[$];
	out_item_t expected_products[$];

	// predictor copy of the stores and dimension registers
	logic signed [IN_VALUE_BITS-1:0] a_elems [MAX_DIM*MAX_DIM];
	logic signed [IN_VALUE_BITS-1:0] b_elems [MAX_DIM*MAX_DIM];
	logic [DIM_REG_BITS-1:0] rows_reg, inner_reg, cols_reg;

	// generator view, used only to keep runs on written entries
	int plan_rows, plan_inner, plan_cols;
	bit a_written [MAX_DIM*MAX_DIM];
	bit b_written [MAX_DIM*MAX_DIM];
	int items_planned;

	int error_count;
	int results_seen;
	int runs_seen;
	int cfg_writes;
	int quiet_cycles;
	int unsigned cycle_no;
	int settle_left;
	int hold_left;
	bit held_once;

	function automatic int dim_in_use(logic [DIM_REG_BITS-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	function automatic bit take_break();
		if (cycle_no >= CALM_FROM && cycle_no < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 14;
	endfunction

	function automatic logic signed [IN_VALUE_BITS-1:0] rand_elem();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return IN_VALUE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_REG_BITS-1:0] rand_dim();
		int pick;
		pick = $urandom_range(9);
		if (pick < 6)
			return DIM_REG_BITS'($urandom_range(4, 1));
		if (pick == 6)
			return DIM_REG_BITS'(MAX_DIM);
		if (pick == 7)
			return '0;
		return DIM_REG_BITS'($urandom_range(15, 9));
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function automatic void predict_products(in_item_t it);
		int nr, nk, nc;
		longint sum;
		out_item_t elem;
		nr = dim_in_use(rows_reg);
		nk = dim_in_use(inner_reg);
		nc = dim_in_use(cols_reg);
		case (it.op)
			OP_LOAD_A: a_elems[{it.elem_row, it.elem_col}] = it.elem_value;
			OP_LOAD_B: b_elems[{it.elem_row, it.elem_col}] = it.elem_value;
			OP_RUN: begin
				runs_seen++;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						sum = 0;
						for (int k = 0; k < nk; k++)
							sum += longint'(a_elems[i*MAX_DIM+k]) * longint'(b_elems[k*MAX_DIM+j]);
						elem.out_row = ROW_BITS'(i);
						elem.out_col = COL_BITS'(j);
						elem.dot_value = DOT_BITS'(sum);
						elem.last = (i == nr - 1) && (j == nc - 1);
						expected_products.push_back(elem);
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic plan_item(input logic [1:0] op, input int r, input int c,
			input logic signed [IN_VALUE_BITS-1:0] v);
		plan_step_t s;
		s.kind = SEND_ITEM;
		s.item.op = op;
		s.item.elem_row = ROW_BITS'(r);
		s.item.elem_col = COL_BITS'(c);
		s.item.elem_value = v;
		s.cfg = '0;
		pending_steps.push_back(s);
		items_planned++;
		if (op == OP_LOAD_A)
			a_written[r*MAX_DIM+c] = 1'b1;
		else if (op == OP_LOAD_B)
			b_written[r*MAX_DIM+c] = 1'b1;
	endtask

	task automatic plan_run();
		plan_item(OP_RUN, $urandom_range(7), $urandom_range(7), rand_elem());
	endtask

	task automatic plan_setting(input logic [DIM_REG_BITS-1:0] r,
			input logic [DIM_REG_BITS-1:0] k, input logic [DIM_REG_BITS-1:0] c);
		plan_step_t s;
		s.item = '0;
		s.kind = WAIT_IDLE;
		s.cfg = '0;
		pending_steps.push_back(s);
		s.kind = SEND_CFG;
		s.cfg.reg_index = REG_ROWS_A;
		s.cfg.wdata = r;
		pending_steps.push_back(s);
		s.cfg.reg_index = REG_INNER_LEN;
		s.cfg.wdata = k;
		pending_steps.push_back(s);
		s.cfg.reg_index = REG_COLS_B;
		s.cfg.wdata = c;
		pending_steps.push_back(s);
		plan_rows = dim_in_use(r);
		plan_inner = dim_in_use(k);
		plan_cols = dim_in_use(c);
	endtask

	// load every entry the next run reads that has never been written
	task automatic cover_region();
		for (int i = 0; i < plan_rows; i++)
			for (int k = 0; k < plan_inner; k++)
				if (!a_written[i*MAX_DIM+k])
					plan_item(OP_LOAD_A, i, k, rand_elem());
		for (int k = 0; k < plan_inner; k++)
			for (int j = 0; j < plan_cols; j++)
				if (!b_written[k*MAX_DIM+j])
					plan_item(OP_LOAD_B, k, j, rand_elem());
	endtask

	task automatic plan_stimulus();
		logic signed [IN_VALUE_BITS-1:0] v;
		int extra;

		// directed: extreme values, unused op, clamped dimension registers
		plan_setting(4'd1, 4'd1, 4'd1);
		plan_item(OP_LOAD_A, 0, 0, 16'sh8000);
		plan_item(OP_LOAD_B, 0, 0, 16'sh8000);
		plan_run();
		plan_item(OP_LOAD_A, 0, 0, 16'sh7fff);
		plan_run();
		plan_item(OP_UNUSED, 7, 7, 16'sh7fff);
		plan_item(OP_LOAD_A, 7, 7, -16'sd1);
		plan_setting(4'd0, 4'd1, 4'd15);
		cover_region();
		plan_run();
		plan_setting(4'd2, 4'd2, 4'd1);
		cover_region();
		plan_run();

		// full size: rows 0/1 of A and cols 0/1 of B drive the largest sums
		plan_setting(4'd8, 4'd8, 4'd8);
		for (int r = 0; r < MAX_DIM; r++) begin
			for (int c = 0; c < MAX_DIM; c++) begin
				v = (r < 2) ? 16'sh8000 : rand_elem();
				plan_item(OP_LOAD_A, r, c, v);
				if (c == 0)
					v = 16'sh8000;
				else if (c == 1)
					v = 16'sh7fff;
				else
					v = rand_elem();
				plan_item(OP_LOAD_B, r, c, v);
			end
		end
		plan_run();
		// these are offered while the result side holds off
		for (int n = 0; n < 4; n++)
			plan_item(n[0] ? OP_LOAD_B : OP_LOAD_A, $urandom_range(7), $urandom_range(7),
				rand_elem());
		plan_run();

		while (items_planned < ITEM_TARGET) begin
			plan_setting(rand_dim(), rand_dim(), rand_dim());
			cover_region();
			do begin
				extra = $urandom_range(6);
				for (int n = 0; n < extra; n++) begin
					if ($urandom_range(9) == 0)
						plan_item(OP_UNUSED, $urandom_range(7), $urandom_range(7), rand_elem());
					else
						plan_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
							$urandom_range(7), $urandom_range(7), rand_elem());
				end
				plan_run();
			end while ($urandom_range(9) < 4);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// sender: one step of the plan at a time
	always @(posedge clk or negedge arst_n) begin : feed
		logic next_item_valid;
		logic next_cfg_valid;
		plan_step_t head;
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.data <= '0;
			cfg_if.valid <= 1'b0;
			cfg_if.data <= '0;
			settle_left = 0;
		end else begin
			next_item_valid = item_if.valid && !item_if.ready;
			next_cfg_valid = cfg_if.valid && !cfg_if.ready;
			if (!next_item_valid && !next_cfg_valid) begin
				if (settle_left > 0) begin
					settle_left--;
				end else if (pending_steps.size() != 0) begin
					head = pending_steps[0];
					case (head.kind)
						SEND_ITEM: begin
							if (!take_break()) begin
								next_item_valid = 1'b1;
								item_if.data <= head.item;
								void'(pending_steps.pop_front());
							end
						end
						SEND_CFG: begin
							if (!take_break()) begin
								next_cfg_valid = 1'b1;
								cfg_if.data <= head.cfg;
								void'(pending_steps.pop_front());
							end
						end
						WAIT_IDLE: begin
							// valid still high means the last transfer is only now being predicted
							if (!item_if.valid && expected_products.size() == 0) begin
								settle_left = SETTLE_CYCLES;
								void'(pending_steps.pop_front());
							end
						end
						default: ;
					endcase
				end
			end
			item_if.valid <= next_item_valid;
			cfg_if.valid <= next_cfg_valid;
		end
	end

	// receiver: random stalls plus one long hold-off in the middle of the full-size run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			hold_left = 0;
			held_once = 1'b0;
		end else begin
			if (result_if.valid && result_if.ready && !held_once &&
					result_if.data.out_row == 3 && result_if.data.out_col == 3) begin
				hold_left = HOLD_CYCLES;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= !take_break();
			end
		end
	end

	always @(posedge clk) begin : watch
		out_item_t want;
		logic any_transfer;
		if (arst_n) begin
			cycle_no++;
			any_transfer = 1'b0;
			if (result_if.valid && result_if.ready) begin
				any_transfer = 1'b1;
				results_seen++;
				if (expected_products.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result row %0d col %0d value %0d last %0d",
						$time, result_if.data.out_row, result_if.data.out_col,
						result_if.data.dot_value, result_if.data.last);
				end else begin
					want = expected_products.pop_front();
					check_field("out_row", want.out_row, result_if.data.out_row);
					check_field("out_col", want.out_col, result_if.data.out_col);
					check_field("dot_value", longint'(want.dot_value),
						longint'(result_if.data.dot_value));
					check_field("last", want.last, result_if.data.last);
				end
			end
			if (item_if.valid && item_if.ready) begin
				any_transfer = 1'b1;
				predict_products(item_if.data);
			end
			if (cfg_if.valid && cfg_if.ready) begin
				any_transfer = 1'b1;
				cfg_writes++;
				case (cfg_if.data.reg_index)
					REG_ROWS_A: rows_reg = cfg_if.data.wdata;
					REG_INNER_LEN: inner_reg = cfg_if.data.wdata;
					REG_COLS_B: cols_reg = cfg_if.data.wdata;
					default: ;
				endcase
			end
			quiet_cycles = any_transfer ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		rows_reg = DIM_RESET;
		inner_reg = DIM_RESET;
		cols_reg = DIM_RESET;
		plan_rows = MAX_DIM;
		plan_inner = MAX_DIM;
		plan_cols = MAX_DIM;
		error_count = 0;
		results_seen = 0;
		runs_seen = 0;
		cfg_writes = 0;
		quiet_cycles = 0;
		cycle_no = 0;
		items_planned = 0;
		plan_stimulus();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_steps.size() != 0 || item_if.valid || cfg_if.valid ||
				expected_products.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_products.size() != 0) begin
			error_count++;
			$display("%0t: %0d result elements never arrived", $time, expected_products.size());
		end

		$display("covered %0d input items, %0d runs, %0d result elements checked",
			items_planned, runs_seen, results_seen);
		$display("%0d register writes incl. zero and over-range dims, one long result stall",
			cfg_writes);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: matrix_multiply_engine_top.f
hw/rtl/mme_pkg.sv
hw/rtl/mme_stream_if.sv
hw/rtl/matrix_multiply_engine_top.sv
sim/tb_matrix_multiply_engine_top.sv
